@@ design/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg: shared types, constants and functions
// fixed-point widths, angle table and output rounding for the euler converter
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int ARG_W             = 36;  // atan2 argument width
  localparam int ANG_W             = 28;  // angle width, Q.24
  localparam int REM_W             = 57;  // radicand width, up to 2^56
  localparam int ROOT_W            = 29;  // floor square root width
  localparam int OUT_W             = 16;

  localparam logic signed [ANG_W-1:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [OUT_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [OUT_W-1:0] HALF_PI_Q13 = 16'sd12868;

  typedef struct packed {
    logic en;   // pipeline advances
    logic vld;  // item present at this point
  } pipe_ctl_t;

  // atan(2^-i) in Q.24
  function automatic logic signed [ANG_W-1:0] atan_q24(input int idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0:       a = 28'sd13176795;
      1:       a = 28'sd7778716;
      2:       a = 28'sd4110060;
      3:       a = 28'sd2086331;
      4:       a = 28'sd1047214;
      5:       a = 28'sd524117;
      6:       a = 28'sd262123;
      7:       a = 28'sd131069;
      default: a = (idx < ATAN_ENTRIES) ? (28'sd1 <<< (24 - idx)) : 28'sd0;
    endcase
    return a;
  endfunction

  // Q.24 to Q.13, half away from zero, then saturate to +/- lim
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ANG_W-1:0] a,
                                                        input logic signed [OUT_W-1:0] lim);
    logic [ANG_W-1:0]        mag;
    logic [ANG_W-1:0]        rm;
    logic signed [ANG_W-1:0] r;
    logic signed [ANG_W-1:0] l;
    mag = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
    rm  = (mag + ANG_W'(1024)) >> 11;
    r   = a[ANG_W-1] ? -$signed(rm) : $signed(rm);
    l   = ANG_W'(lim);
    if (r > l) begin
      r = l;
    end else if (r < -l) begin
      r = -l;
    end
    return r[OUT_W-1:0];
  endfunction

endpackage

@@ design/qte_isqrt.sv @@
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined floor square root
// one result bit per stage, restoring, ROOT_W stages
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qte_pkg::pipe_ctl_t           ctl,
  input  logic [qte_pkg::REM_W-1:0]    rad,
  output logic                         root_vld,
  output logic [qte_pkg::ROOT_W-1:0]   root
);

  localparam int RW = qte_pkg::REM_W;
  localparam int QW = qte_pkg::ROOT_W;
  localparam int TW = RW + 2;

  logic [RW-1:0] rem_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          vld_r [0:QW];

  assign rem_r[0] = rad;
  assign q_r[0]   = '0;
  assign vld_r[0] = ctl.vld;

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int K = QW - 1 - j;
    logic [TW-1:0] trial;
    logic [TW-1:0] rext;
    logic          ge;

    assign trial = (TW'(q_r[j]) << (K + 1)) + (TW'(1) << (2 * K));
    assign rext  = TW'(rem_r[j]);
    assign ge    = rext >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[j+1] <= ge ? RW'(rext - trial) : rem_r[j];
        q_r[j+1]   <= ge ? (q_r[j] | (QW'(1) << K)) : q_r[j];
      end
    end
  end

  assign root_vld = vld_r[QW];
  assign root     = q_r[QW];

endmodule

@@ design/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring cordic, atan2(y, x)
// one pre-rotation stage then one micro-rotation per stage, angle in Q.24
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qte_pkg::pipe_ctl_t                 ctl,
  input  logic signed [qte_pkg::ARG_W-1:0]   y_in,
  input  logic signed [qte_pkg::ARG_W-1:0]   x_in,
  output logic                               ang_vld,
  output logic signed [qte_pkg::ANG_W-1:0]   ang
);

  localparam int W  = qte_pkg::ARG_W + 4;
  localparam int ZW = qte_pkg::ANG_W;

  logic signed [W-1:0]  x_r    [0:STAGES];
  logic signed [W-1:0]  y_r    [0:STAGES];
  logic signed [ZW-1:0] z_r    [0:STAGES];
  logic                 zero_r [0:STAGES];
  logic                 vld_r  [0:STAGES];

  logic signed [W-1:0]  x_ext;
  logic signed [W-1:0]  y_ext;

  assign x_ext = W'(x_in);
  assign y_ext = W'(y_in);

  // move into the right half plane
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x_r[0]    <= x_in[qte_pkg::ARG_W-1] ? -x_ext : x_ext;
      y_r[0]    <= x_in[qte_pkg::ARG_W-1] ? -y_ext : y_ext;
      z_r[0]    <= !x_in[qte_pkg::ARG_W-1] ? '0 :
                   (y_in[qte_pkg::ARG_W-1] ? -qte_pkg::PI_Q24 : qte_pkg::PI_Q24);
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ctl.en) begin
      vld_r[0] <= ctl.vld;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN_I = qte_pkg::atan_q24(i);
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if (!y_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  assign ang_vld = vld_r[STAGES];
  assign ang     = zero_r[STAGES] ? '0 : z_r[STAGES];

endmodule

@@ design/quaternion_to_euler.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler: quaternion (Q1.14) to roll, pitch, yaw (Q2.13)
// products, quadratic forms, pipelined square root and three cordic units
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the output stalls; the depth is set by the
//   29-stage square root followed by the cordic pipelines that run roll, pitch and yaw
//   side by side
// a stalled output register holds the whole pipeline; nothing is lost
// reset clears the valid bits only; the block keeps no state between items
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle, pitch_angle(15), yaw_angle, zero pad
  output logic        out_tuser   // pitch_clamped
);

  localparam int AW  = qte_pkg::ARG_W;
  localparam int SQN = qte_pkg::ROOT_W;

  typedef struct packed {
    logic signed [AW-1:0] rn;
    logic signed [AW-1:0] rd;
    logic signed [AW-1:0] yn;
    logic signed [AW-1:0] yd;
    logic signed [AW-1:0] s;
    logic                 clamp;
  } side_t;

  // pipeline advances unless the output register is full and stalled
  logic               adv;
  qte_pkg::pipe_ctl_t ctl_in;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---- stage 1: all nine products, exact
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = in_tdata[15:0];
  assign qy = in_tdata[31:16];
  assign qz = in_tdata[47:32];
  assign qw = in_tdata[63:48];

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, zz_r, wz_r, xy_r, wy_r, zx_r;
  logic               v1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r <= qw * qx;
      yz_r <= qy * qz;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      wz_r <= qw * qz;
      xy_r <= qx * qy;
      wy_r <= qw * qy;
      zx_r <= qz * qx;
    end
  end

  // ---- stage 2: quadratic forms and the clamp test
  localparam logic signed [AW-1:0] ONE_Q28 = AW'(1) <<< 28;

  side_t s2_nxt, s2_r;
  logic  v2_r;

  always_comb begin
    s2_nxt.rn    = (AW'(wx_r) + AW'(yz_r)) <<< 1;
    s2_nxt.rd    = ONE_Q28 - ((AW'(xx_r) + AW'(yy_r)) <<< 1);
    s2_nxt.yn    = (AW'(wz_r) + AW'(xy_r)) <<< 1;
    s2_nxt.yd    = ONE_Q28 - ((AW'(yy_r) + AW'(zz_r)) <<< 1);
    s2_nxt.s     = (AW'(wy_r) - AW'(zx_r)) <<< 1;
    s2_nxt.clamp = (s2_nxt.s >= ONE_Q28) || (s2_nxt.s <= -ONE_Q28);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  // ---- stage 3: radicand 1 - s^2 in Q.56
  logic [AW-1:0]                  s_mag;
  logic [27:0]                    s_mag28;
  logic [55:0]                    s_sq;
  logic [qte_pkg::REM_W-1:0]      rad_r;
  side_t                          s3_r;
  logic                           v3_r;

  assign s_mag   = s2_r.s[AW-1] ? AW'(-s2_r.s) : AW'(s2_r.s);
  assign s_mag28 = s_mag[27:0];
  assign s_sq    = s_mag28 * s_mag28;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r <= (qte_pkg::REM_W'(1) << 56) - qte_pkg::REM_W'(s_sq);
      s3_r  <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // ---- square root, with the other terms riding alongside
  qte_pkg::pipe_ctl_t   sq_ctl;
  logic                 root_vld;
  logic [SQN-1:0]       root;
  side_t                side_r [0:SQN];

  assign sq_ctl.en  = adv;
  assign sq_ctl.vld = v3_r;
  assign side_r[0]  = s3_r;

  qte_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .rad      (rad_r),
    .root_vld (root_vld),
    .root     (root)
  );

  for (genvar k = 0; k < SQN; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // ---- three cordic units in lock step
  qte_pkg::pipe_ctl_t          cd_ctl;
  side_t                       sd;
  logic signed [AW-1:0]        cos_arg;
  logic                        roll_vld, pitch_vld, yaw_vld;
  logic signed [qte_pkg::ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;

  assign cd_ctl.en  = adv;
  assign cd_ctl.vld = root_vld;
  assign sd         = side_r[SQN];
  assign cos_arg    = AW'(root);

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .rst_n (rst_n), .ctl (cd_ctl),
    .y_in (sd.rn), .x_in (sd.rd), .ang_vld (roll_vld), .ang (roll_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .rst_n (rst_n), .ctl (cd_ctl),
    .y_in (sd.s), .x_in (cos_arg), .ang_vld (pitch_vld), .ang (pitch_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .rst_n (rst_n), .ctl (cd_ctl),
    .y_in (sd.yn), .x_in (sd.yd), .ang_vld (yaw_vld), .ang (yaw_ang)
  );

  // clamp flag and sign of s follow the cordic depth
  logic clamp_d_r [0:CORDIC_STAGES+1];
  logic sneg_d_r  [0:CORDIC_STAGES+1];

  assign clamp_d_r[0] = sd.clamp;
  assign sneg_d_r[0]  = sd.s[AW-1];

  for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_clamp
    always_ff @(posedge clk) begin
      if (adv) begin
        clamp_d_r[k+1] <= clamp_d_r[k];
        sneg_d_r[k+1]  <= sneg_d_r[k];
      end
    end
  end

  // ---- output register: rounding, saturation and clamp override
  logic                        clamp_o;
  logic signed [15:0]          roll_q, pitch_q, yaw_q;
  logic signed [15:0]          pitch_sel;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [47:0]                 out_tdata_r;
  logic                        out_tuser_r;

  assign clamp_o   = clamp_d_r[CORDIC_STAGES+1];
  assign roll_q    = qte_pkg::round_sat(roll_ang, qte_pkg::PI_Q13);
  assign yaw_q     = qte_pkg::round_sat(yaw_ang, qte_pkg::PI_Q13);
  assign pitch_q   = qte_pkg::round_sat(pitch_ang, qte_pkg::HALF_PI_Q13);
  assign pitch_sel = !clamp_o ? pitch_q :
                     (sneg_d_r[CORDIC_STAGES+1] ? -qte_pkg::HALF_PI_Q13
                                                : qte_pkg::HALF_PI_Q13);

  assign out_tvalid_nxt = roll_vld && pitch_vld && yaw_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {1'b0, yaw_q, pitch_sel[14:0], roll_q};
      out_tuser_r <= clamp_o;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---- assertions
  logic signed [15:0] a_roll, a_yaw;
  logic signed [14:0] a_pitch;
  assign a_roll  = out_tdata[15:0];
  assign a_pitch = out_tdata[30:16];
  assign a_yaw   = out_tdata[46:31];

  // no item leaves straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // clamped items carry exactly plus or minus half pi
  a_clamp_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (a_pitch == 15'sd12868 || a_pitch == -15'sd12868))
    else $error("clamped pitch is not half pi");

  // angles stay within their saturation limits
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (a_roll <= 16'sd25736 && a_roll >= -16'sd25736 &&
                    a_yaw <= 16'sd25736 && a_yaw >= -16'sd25736 &&
                    a_pitch <= 15'sd12868 && a_pitch >= -15'sd12868))
    else $error("angle out of range");

endmodule
